// ===== sv/ovmli_pkg.sv =====
package ovmli_pkg;

   localparam int TABLE_ENTRIES = 201;
   localparam int TOP_INDEX     = TABLE_ENTRIES - 1;
   localparam int IDX_W         = 8;
   localparam int MOD_W         = 18;
   localparam int LIM_W         = 8;
   localparam int REGION_W      = 2;

   localparam logic [LIM_W-1:0] LIMIT_RESET = 8'd150;
   localparam logic [LIM_W-1:0] LIMIT_MAX   = 8'd200;

   localparam logic [REGION_W-1:0] REGION_PASS   = 2'd0;
   localparam logic [REGION_W-1:0] REGION_INTERP = 2'd1;
   localparam logic [REGION_W-1:0] REGION_CLAMP  = 2'd2;
   localparam logic [REGION_W-1:0] REGION_FULL   = 2'd3;

   // table entries are exact in units of 1e-7
   localparam logic [63:0] E7_SCALE = 64'd10000000;
   localparam logic [63:0] E7_HALF  = 64'd5000000;
   localparam logic [63:0] STEP_DIV = 64'd200;
   localparam logic [63:0] STEP_RND = 64'd100;

   localparam logic [23:0] ROM_E7 [TABLE_ENTRIES] = '{
      24'd10000000,24'd10043642,24'd10082038,24'd10117043,24'd10149323,24'd10179264,
      24'd10207129,24'd10233112,24'd10257364,24'd10280007,24'd10301143,24'd10320858,
      24'd10339226,24'd10356311,24'd10372173,24'd10386862,24'd10400425,24'd10412903,
      24'd10424337,24'd10434759,24'd10444205,24'd10452702,24'd10460281,24'd10466967,
      24'd10472784,24'd10477756,24'd10481904,24'd10485249,24'd10487811,24'd10489607,
      24'd10490656,24'd10490975,24'd10491321,24'd10492317,24'd10493900,24'd10496015,
      24'd10498612,24'd10501646,24'd10505074,24'd10508859,24'd10512966,24'd10517364,
      24'd10522023,24'd10526917,24'd10532022,24'd10537315,24'd10542776,24'd10548386,
      24'd10554128,24'd10559986,24'd10565944,24'd10571990,24'd10578111,24'd10584295,
      24'd10590532,24'd10596811,24'd10603124,24'd10609462,24'd10615817,24'd10622183,
      24'd10628552,24'd10634919,24'd10641278,24'd10647623,24'd10653950,24'd10660254,
      24'd10666531,24'd10672778,24'd10678990,24'd10685165,24'd10691300,24'd10697392,
      24'd10703439,24'd10709437,24'd10715386,24'd10721283,24'd10727127,24'd10732915,
      24'd10738647,24'd10744321,24'd10749936,24'd10755491,24'd10760985,24'd10766417,
      24'd10771787,24'd10777094,24'd10782337,24'd10787515,24'd10792629,24'd10797678,
      24'd10802662,24'd10807580,24'd10812433,24'd10817220,24'd10821942,24'd10826597,
      24'd10831187,24'd10835711,24'd10840170,24'd10844563,24'd10848892,24'd10853155,
      24'd10857353,24'd10861487,24'd10865557,24'd10869562,24'd10873505,24'd10877384,
      24'd10881200,24'd10884953,24'd10888645,24'd10892275,24'd10895843,24'd10899351,
      24'd10902799,24'd10906186,24'd10909514,24'd10912784,24'd10915994,24'd10919147,
      24'd10922242,24'd10925280,24'd10928262,24'd10931187,24'd10934057,24'd10936872,
      24'd10939633,24'd10942339,24'd10944992,24'd10947592,24'd10950140,24'd10952635,
      24'd10955080,24'd10957473,24'd10959816,24'd10962109,24'd10964353,24'd10966548,
      24'd10968695,24'd10970794,24'd10972845,24'd10974850,24'd10976808,24'd10978721,
      24'd10980588,24'd10982410,24'd10984188,24'd10985923,24'd10987614,24'd10989262,
      24'd10990867,24'd10992431,24'd10993953,24'd10995435,24'd10996875,24'd10998276,
      24'd10999637,24'd11000959,24'd11002243,24'd11003488,24'd11004695,24'd11005865,
      24'd11006998,24'd11008094,24'd11009155,24'd11010179,24'd11011169,24'd11012123,
      24'd11013044,24'd11013930,24'd11014783,24'd11015602,24'd11016389,24'd11017143,
      24'd11017865,24'd11018556,24'd11019215,24'd11019843,24'd11020441,24'd11021009,
      24'd11021547,24'd11022055,24'd11022535,24'd11022986,24'd11023408,24'd11023802,
      24'd11024169,24'd11024508,24'd11024820,24'd11025106,24'd11025365,24'd11025599,
      24'd11025806,24'd11025988,24'd11026145,24'd11026278,24'd11026385,24'd11026469,
      24'd11026529,24'd11026565,24'd11026578
   };

   // table entry to fixed point, round to nearest, ties up
   function automatic logic [63:0] rom_to_q(input logic [23:0] e7, input int fb);
      return ((64'(e7) << fb) + E7_HALF) / E7_SCALE;
   endfunction

   // clamp level 2 - lim/200 in fixed point
   function automatic logic [63:0] clamp_to_q(input int lim, input int fb);
      return ((64'(2 * TOP_INDEX - lim) << fb) + STEP_RND) / STEP_DIV;
   endfunction

endpackage

// ===== sv/ovmli_rom.sv =====
module ovmli_rom #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic [ovmli_pkg::IDX_W-1:0]   rd_addr,
   output logic [FRAC_BITS+1:0]          rd_data
);
   import ovmli_pkg::*;

   localparam int QW = FRAC_BITS + 2;

   logic [QW-1:0] rom_mem [TABLE_ENTRIES];
   logic [QW-1:0] rd_data_ff;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_entry
      assign rom_mem[g] = QW'(rom_to_q(ROM_E7[g], FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rom_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ovmli_div.sv =====
module ovmli_div #(
   parameter int NW = 44,
   parameter int DW = 26,
   parameter int QB = 18
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [QB-1:0] quotient
);
   import ovmli_pkg::*;

   localparam int CNTW = $clog2(QB + 1);

   logic [DW-1:0]   rem_ff, rem_in;
   logic [QB-1:0]   low_ff, low_in;
   logic [DW-1:0]   dsr_ff, dsr_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [DW:0]     trial;
   logic [DW:0]     trial_sub;
   logic            fits;

   // one quotient bit per cycle, restoring
   assign trial     = {rem_ff, low_ff[QB-1]};
   assign fits      = trial >= {1'b0, dsr_ff};
   assign trial_sub = trial - {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         // high part is below the divisor since the quotient fits QB bits
         rem_in = DW'(dividend[NW-1:QB]);
         low_in = dividend[QB-1:0];
         dsr_in = divisor;
         cnt_in = CNTW'(QB);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? trial_sub[DW-1:0] : trial[DW-1:0];
         low_in = {low_ff[QB-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = low_ff;

endmodule

// ===== sv/overmodulation_index_linearizer.sv =====
// Overmodulation index linearizer. Pulse start while busy is low to hand in one
// modulation index word (unsigned, FRAC_BITS fraction bits); busy stays high until
// the result word appears on the rsp_ ports for exactly one cycle with rsp_valid
// high. The receiver cannot stall, so it must take the word in that cycle.
// Passthrough, clamped and full-scale words are decided in the check state, from
// the ROM word at the clamp threshold; interpolated ones use the binary search
// over the 201-entry ROM (one synchronous read per step, at most eight steps) and
// the serial divider (one quotient bit per cycle, FRAC_BITS + 2 bits). A new
// start is taken in the cycle the result is shown. Write csr_write_data only
// while busy is low; values above 200 act as 200.
module overmodulation_index_linearizer #(
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ovmli_pkg::MOD_W-1:0]      req_modulation_index,
   output logic                             rsp_valid,
   output logic [ovmli_pkg::MOD_W-1:0]      rsp_corrected_index,
   output logic [ovmli_pkg::REGION_W-1:0]   rsp_region,
   input  logic                             csr_write_en,
   input  logic [ovmli_pkg::LIM_W-1:0]      csr_write_data
);
   import ovmli_pkg::*;

   localparam int QW = FRAC_BITS + 2;
   localparam int CW = (QW > MOD_W) ? QW : MOD_W;
   localparam int PW = QW + 9;
   localparam int DW = QW + 8;
   localparam int NW = PW + 1 + FRAC_BITS;

   localparam logic [CW-1:0]    ONE_Q   = CW'(64'd1 << FRAC_BITS);
   localparam logic [QW-1:0]    T_FIRST = QW'(rom_to_q(ROM_E7[0], FRAC_BITS));
   localparam logic [QW-1:0]    T_TOP   = QW'(rom_to_q(ROM_E7[TOP_INDEX], FRAC_BITS));
   localparam logic [MOD_W-1:0] FULL_Q  = MOD_W'(64'd2 << FRAC_BITS);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_SEARCH = 6'b000100,
      ST_MUL    = 6'b001000,
      ST_SUM    = 6'b010000,
      ST_DIV    = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [LIM_W-1:0]  limit_ff, limit_in;
   logic [MOD_W-1:0]  m_ff, m_in;
   logic [IDX_W-1:0]  lim_ff, lim_in;
   logic [IDX_W-1:0]  thresh_ff, thresh_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [IDX_W-1:0]  mid_ff, mid_in;
   logic [QW-1:0]     t_lo_ff, t_lo_in;
   logic [QW-1:0]     t_hi_ff, t_hi_in;
   logic [PW-1:0]     prod_ff, prod_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [QW-1:0]     diff_ff, diff_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MOD_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [REGION_W-1:0] rsp_region_ff, rsp_region_in;

   logic [MOD_W-1:0]  clamp_tab [TABLE_ENTRIES];
   logic [IDX_W-1:0]  lim_sat;
   logic [IDX_W-1:0]  thresh_now;
   logic [IDX_W-1:0]  rom_addr;
   logic [QW-1:0]     rom_q;
   logic [CW-1:0]     m_ext;
   logic [CW-1:0]     rom_ext;
   logic              below;
   logic [IDX_W-1:0]  lo_nx, hi_nx, gap_nx;
   logic [IDX_W:0]    mid_sum;
   logic [QW-1:0]     d_val;
   logic [IDX_W:0]    mult_lo;
   logic [NW-1:0]     num;
   logic              div_start;
   logic              div_done;
   logic [QW-1:0]     div_q;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_clamp
      assign clamp_tab[g] = MOD_W'(clamp_to_q(g, FRAC_BITS));
   end

   ovmli_rom #(.FRAC_BITS(FRAC_BITS)) u_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_q)
   );

   ovmli_div #(.NW(NW), .DW(DW), .QB(QW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign lim_sat    = (limit_ff > LIMIT_MAX) ? LIMIT_MAX : limit_ff;
   assign thresh_now = IDX_W'(TOP_INDEX) - lim_sat;
   assign m_ext      = CW'(m_ff);
   assign rom_ext    = CW'(rom_q);
   assign below      = rom_ext < m_ext;

   // narrow the bracket with the entry at mid that just came back
   assign lo_nx   = below ? mid_ff : lo_ff;
   assign hi_nx   = below ? hi_ff : mid_ff;
   assign gap_nx  = hi_nx - lo_nx;
   assign mid_sum = {1'b0, lo_nx} + {1'b0, hi_nx};

   assign d_val   = t_hi_ff - t_lo_ff;
   assign mult_lo = (IDX_W + 1)'(TOP_INDEX) + {1'b0, lo_ff};
   assign num     = ((NW'(prod_ff) + NW'(diff_ff)) << FRAC_BITS) + NW'(den_ff >> 1);
   assign div_start = (state_ff == ST_SUM);

   always_comb begin
      rom_addr = mid_ff;
      case (state_ff)
         ST_IDLE:   rom_addr = thresh_now;
         ST_CHECK:  rom_addr = thresh_ff >> 1;
         ST_SEARCH: rom_addr = mid_sum[IDX_W:1];
         default:   rom_addr = mid_ff;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      limit_in      = csr_write_en ? csr_write_data : limit_ff;
      m_in          = m_ff;
      lim_in        = lim_ff;
      thresh_in     = thresh_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      t_lo_in       = t_lo_ff;
      t_hi_in       = t_hi_ff;
      prod_in       = prod_ff;
      den_in        = den_ff;
      diff_in       = diff_ff;
      rsp_valid_in  = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_region_in = rsp_region_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               m_in      = req_modulation_index;
               lim_in    = lim_sat;
               thresh_in = thresh_now;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // ROM word is the entry at the clamp threshold
            if (m_ext >= rom_ext) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = clamp_tab[lim_ff];
               rsp_region_in = REGION_CLAMP;
               state_in      = ST_IDLE;
            end else if (m_ext <= ONE_Q) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = m_ff;
               rsp_region_in = REGION_PASS;
               state_in      = ST_IDLE;
            end else if (m_ext >= CW'(T_TOP)) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = FULL_Q;
               rsp_region_in = REGION_FULL;
               state_in      = ST_IDLE;
            end else begin
               lo_in   = '0;
               hi_in   = thresh_ff;
               mid_in  = thresh_ff >> 1;
               t_lo_in = T_FIRST;
               t_hi_in = rom_q;
               state_in = (thresh_ff > IDX_W'(1)) ? ST_SEARCH : ST_MUL;
            end
         end
         ST_SEARCH: begin
            lo_in   = lo_nx;
            hi_in   = hi_nx;
            mid_in  = mid_sum[IDX_W:1];
            t_lo_in = below ? rom_q : t_lo_ff;
            t_hi_in = below ? t_hi_ff : rom_q;
            if (gap_nx <= IDX_W'(1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PW'(mult_lo) * PW'(d_val);
            den_in   = DW'(d_val) * DW'(TOP_INDEX);
            diff_in  = QW'(m_ext - CW'(t_lo_ff));
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = MOD_W'(div_q);
               rsp_region_in = REGION_INTERP;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff          <= m_in;
      lim_ff        <= lim_in;
      thresh_ff     <= thresh_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      t_lo_ff       <= t_lo_in;
      t_hi_ff       <= t_hi_in;
      prod_ff       <= prod_in;
      den_ff        <= den_in;
      diff_ff       <= diff_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_region_ff <= rsp_region_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_corrected_index = rsp_index_ff;
   assign rsp_region          = rsp_region_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still working");

   a_bracket: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> lo_ff < mid_ff && mid_ff < hi_ff)
      else $error("search midpoint outside bracket");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");

endmodule
